### hw/rtl/slewed_fractional_delay_line_assert.svh
// Assertion macros shared by the delay line RTL.
// Both macros expect clk_i and rst_ni in scope.
`ifndef SLEWED_FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define SLEWED_FRACTIONAL_DELAY_LINE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define SFDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SFDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sfdl_pkg.sv
package sfdl_pkg;

  // Default configuration of the delay line
  localparam int unsigned MAX_DELAY_DEF   = 1023;
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned DELAY_W_DEF     = $clog2(MAX_DELAY_DEF + 1) + FRAC_BITS_DEF;

  // Per-tap source select, shared by both lanes
  typedef struct packed {
    logic fwd_early;   // early tap is the word being written now
    logic fwd_late;    // late tap is the word being written now
    logic live_early;  // early tap was written since the last clear
    logic live_late;   // late tap was written since the last clear
  } sel_t;

endpackage

### hw/rtl/sfdl_if.sv
// Input channel: one stereo word or a restart request.
interface sfdl_in_if #(
  parameter int unsigned SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output restart, output in_left, output in_right,
                  input ready);
  modport sink   (input valid, input restart, input in_left, input in_right,
                  output ready);
endinterface

// Output channel: one interpolated stereo word and the delay in use.
interface sfdl_out_if #(
  parameter int unsigned SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DELAY_W     = sfdl_pkg::DELAY_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic        [DELAY_W-1:0]     delay_now;

  modport source (output valid, output out_left, output out_right, output delay_now,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input delay_now,
                  output ready);
endinterface

### hw/rtl/sfdl_ctrl.sv
`include "slewed_fractional_delay_line_assert.svh"

module sfdl_ctrl #(
  parameter int unsigned MAX_DELAY = sfdl_pkg::MAX_DELAY_DEF,
  parameter int unsigned FRAC_BITS = sfdl_pkg::FRAC_BITS_DEF,
  parameter int unsigned PTR_W     = $clog2(MAX_DELAY + 1),
  parameter int unsigned DELAY_W   = PTR_W + FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [DELAY_W-1:0]   cfg_wdata_i,
  input  logic                 en_i,
  input  logic                 accept_i,
  input  logic                 restart_i,
  output logic                 wr_en_o,
  output logic [PTR_W-1:0]     wr_addr_o,
  output logic [PTR_W-1:0]     rd_early_addr_o,
  output logic [PTR_W-1:0]     rd_late_addr_o,
  output logic                 s1_valid_o,
  output sfdl_pkg::sel_t       s1_sel_o,
  output logic [FRAC_BITS-1:0] s1_frac_o,
  output logic [DELAY_W-1:0]   s1_delay_o
);
  import sfdl_pkg::*;

  localparam logic [DELAY_W-1:0] LIMIT = DELAY_W'(MAX_DELAY) << FRAC_BITS;
  localparam logic [DELAY_W:0]   STEP  = (DELAY_W + 1)'(1) << (FRAC_BITS - 2);
  localparam logic [DELAY_W:0]   SPAN  = (DELAY_W + 1)'(MAX_DELAY + 1) << FRAC_BITS;
  localparam logic [PTR_W-1:0]   LAST  = PTR_W'(MAX_DELAY);

  logic [DELAY_W-1:0] target_q;
  logic [DELAY_W-1:0] cd_q, cd_d;
  logic [PTR_W-1:0]   wp_q;
  logic               full_q;
  logic               s1_valid_q;
  sel_t               s1_sel_q;
  logic [FRAC_BITS-1:0] s1_frac_q;
  logic [DELAY_W-1:0] s1_delay_q;

  logic [DELAY_W-1:0] tgt;
  logic [DELAY_W:0]   cd_up;
  logic [DELAY_W:0]   pos_raw;
  logic [DELAY_W:0]   pos_wrap;
  logic [DELAY_W-1:0] pos;
  logic [PTR_W-1:0]   early_addr;
  logic [PTR_W-1:0]   late_addr;
  sel_t               sel;
  logic [DELAY_W:0]   cd_ext;

  // Saturate the target and slew the delay by at most a quarter frame
  always_comb begin
    tgt   = (target_q > LIMIT) ? LIMIT : target_q;
    cd_up = {1'b0, cd_q} + STEP;
    if ({1'b0, tgt} > cd_up) begin
      cd_d = cd_up[DELAY_W-1:0];
    end else if ({1'b0, cd_q} > ({1'b0, tgt} + STEP)) begin
      cd_d = cd_q - STEP[DELAY_W-1:0];
    end else begin
      cd_d = tgt;
    end
  end

  // Read position behind the write pointer, wrapped into the store
  always_comb begin
    pos_raw  = {1'b0, wp_q, {FRAC_BITS{1'b0}}} - {1'b0, cd_d};
    pos_wrap = pos_raw[DELAY_W] ? (pos_raw + SPAN) : pos_raw;
    pos      = pos_wrap[DELAY_W-1:0];
    early_addr = pos[DELAY_W-1:FRAC_BITS];
    late_addr  = (early_addr == LAST) ? '0 : (early_addr + PTR_W'(1));
  end

  // Pick the source of each tap: the word in flight, the store, or a cleared entry
  always_comb begin
    sel.fwd_early  = (early_addr == wp_q);
    sel.fwd_late   = (late_addr == wp_q);
    sel.live_early = full_q || (early_addr < wp_q);
    sel.live_late  = full_q || (late_addr < wp_q);
  end

  assign wr_en_o         = accept_i && !restart_i;
  assign wr_addr_o       = wp_q;
  assign rd_early_addr_o = early_addr;
  assign rd_late_addr_o  = late_addr;
  assign s1_valid_o      = s1_valid_q;
  assign s1_sel_o        = s1_sel_q;
  assign s1_frac_o       = s1_frac_q;
  assign s1_delay_o      = s1_delay_q;

  // Hold the target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Advance pointer, fill state and delay per accepted word; restart reloads them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
      cd_q   <= '0;
    end else if (accept_i) begin
      if (restart_i) begin
        wp_q   <= '0;
        full_q <= 1'b0;
        cd_q   <= tgt;
      end else begin
        cd_q   <= cd_d;
        wp_q   <= (wp_q == LAST) ? '0 : (wp_q + PTR_W'(1));
        full_q <= full_q || (wp_q == LAST);
      end
    end
  end

  // Stage one valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= accept_i && !restart_i;
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sel_q   <= sel;
      s1_frac_q  <= pos[FRAC_BITS-1:0];
      s1_delay_q <= cd_d;
    end
  end

  assign cd_ext = {1'b0, cd_q};

  `SFDL_ASSERT_NEXT(restart_clears_fill, accept_i && restart_i, (wp_q == '0) && !full_q, "restart left pointer or fill state set")
  `SFDL_ASSERT_NEXT(slew_bounded, accept_i && !restart_i, (cd_ext <= ($past(cd_ext) + STEP)) && ((cd_ext + STEP) >= $past(cd_ext)), "delay moved more than one slew step")
  `SFDL_ASSERT_NOW(delay_in_range, 1'b1, cd_q <= LIMIT, "current delay above maximum")

endmodule

### hw/rtl/sfdl_lane.sv
module sfdl_lane #(
  parameter int unsigned MAX_DELAY   = sfdl_pkg::MAX_DELAY_DEF,
  parameter int unsigned FRAC_BITS   = sfdl_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PTR_W       = $clog2(MAX_DELAY + 1)
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          wr_en_i,
  input  logic [PTR_W-1:0]              wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  input  logic [PTR_W-1:0]              rd_early_addr_i,
  input  logic [PTR_W-1:0]              rd_late_addr_i,
  input  sfdl_pkg::sel_t                sel_i,
  input  logic [FRAC_BITS-1:0]          frac_i,
  output logic signed [SAMPLE_BITS-1:0] interp_o
);
  import sfdl_pkg::*;

  localparam int unsigned DEPTH = MAX_DELAY + 1;
  localparam int unsigned PW    = SAMPLE_BITS + FRAC_BITS + 2;

  logic        [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_early_q;
  logic signed [SAMPLE_BITS-1:0] rd_late_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] early;
  logic signed [SAMPLE_BITS-1:0] late;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_BITS-1:0] early_q;
  logic signed [PW-1:0]          sum;

  // Write the incoming word into the store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= smp_i;
    end
  end

  // Read both taps and keep the incoming word for forwarding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_early_q <= $signed(mem_q[rd_early_addr_i]);
      rd_late_q  <= $signed(mem_q[rd_late_addr_i]);
      smp_q      <= smp_i;
    end
  end

  // Select tap sources, then scale the difference by the fraction
  always_comb begin
    if (sel_i.fwd_early) begin
      early = smp_q;
    end else if (sel_i.live_early) begin
      early = rd_early_q;
    end else begin
      early = '0;
    end
    if (sel_i.fwd_late) begin
      late = smp_q;
    end else if (sel_i.live_late) begin
      late = rd_late_q;
    end else begin
      late = '0;
    end
    diff = $signed({late[SAMPLE_BITS-1], late}) - $signed({early[SAMPLE_BITS-1], early});
    prod = diff * $signed({1'b0, frac_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod;
      early_q <= early;
    end
  end

  // Floor the scaled difference and add it to the early tap
  assign sum      = PW'(early_q) + (prod_q >>> FRAC_BITS);
  assign interp_o = sum[SAMPLE_BITS-1:0];

endmodule

### hw/rtl/slewed_fractional_delay_line.sv
// A result word passes stage one (tap reads), stage two (scaled difference) and the output
// register; a stall holds every stage. Throughput: one word per cycle unless stalled; both
// lanes read two taps and write one entry per sample word. Restart words produce no result.
// Reset (async, active low) clears pointer, fill state, delay, target and valids.
// The store itself is not swept: a fill count masks entries not written since
// the last reset or restart, so the block is ready right after reset.
`include "slewed_fractional_delay_line_assert.svh"

module slewed_fractional_delay_line #(
  parameter int unsigned MAX_DELAY   = sfdl_pkg::MAX_DELAY_DEF,
  parameter int unsigned FRAC_BITS   = sfdl_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned PTR_W       = $clog2(MAX_DELAY + 1),
  parameter int unsigned DELAY_W     = PTR_W + FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DELAY_W-1:0] cfg_wdata_i,
  sfdl_in_if.sink            in_ch,
  sfdl_out_if.source         out_ch
);
  import sfdl_pkg::*;

  logic                          en;
  logic                          accept;
  logic                          wr_en;
  logic [PTR_W-1:0]              wr_addr;
  logic [PTR_W-1:0]              rd_early_addr;
  logic [PTR_W-1:0]              rd_late_addr;
  logic                          s1_valid;
  sel_t                          s1_sel;
  logic [FRAC_BITS-1:0]          s1_frac;
  logic [DELAY_W-1:0]            s1_delay;
  logic signed [SAMPLE_BITS-1:0] interp_left;
  logic signed [SAMPLE_BITS-1:0] interp_right;

  logic                          v2_q;
  logic [DELAY_W-1:0]            d2_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q;
  logic signed [SAMPLE_BITS-1:0] out_right_q;
  logic [DELAY_W-1:0]            out_delay_q;

  // Advance the pipeline unless a finished word is stuck at the output
  assign en          = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && en;
  assign in_ch.ready = en;

  sfdl_ctrl #(
    .MAX_DELAY (MAX_DELAY),
    .FRAC_BITS (FRAC_BITS),
    .PTR_W     (PTR_W),
    .DELAY_W   (DELAY_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .en_i            (en),
    .accept_i        (accept),
    .restart_i       (in_ch.restart),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .rd_early_addr_o (rd_early_addr),
    .rd_late_addr_o  (rd_late_addr),
    .s1_valid_o      (s1_valid),
    .s1_sel_o        (s1_sel),
    .s1_frac_o       (s1_frac),
    .s1_delay_o      (s1_delay)
  );

  sfdl_lane #(
    .MAX_DELAY   (MAX_DELAY),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W)
  ) u_lane_left (
    .clk_i           (clk_i),
    .en_i            (en),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .smp_i           (in_ch.in_left),
    .rd_early_addr_i (rd_early_addr),
    .rd_late_addr_i  (rd_late_addr),
    .sel_i           (s1_sel),
    .frac_i          (s1_frac),
    .interp_o        (interp_left)
  );

  sfdl_lane #(
    .MAX_DELAY   (MAX_DELAY),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W)
  ) u_lane_right (
    .clk_i           (clk_i),
    .en_i            (en),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .smp_i           (in_ch.in_right),
    .rd_early_addr_i (rd_early_addr),
    .rd_late_addr_i  (rd_late_addr),
    .sel_i           (s1_sel),
    .frac_i          (s1_frac),
    .interp_o        (interp_right)
  );

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v2_q        <= s1_valid;
      out_valid_q <= v2_q;
    end
  end

  // Merge both lanes and the delay into the output word
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q        <= s1_delay;
      out_left_q  <= interp_left;
      out_right_q <= interp_right;
      out_delay_q <= d2_q;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_left  = out_left_q;
  assign out_ch.out_right = out_right_q;
  assign out_ch.delay_now = out_delay_q;

  `SFDL_ASSERT_NEXT(stage_two_reaches_output, v2_q && en, out_valid_q, "word lost between stage two and output")
  `SFDL_ASSERT_NEXT(out_held, out_valid_q && !out_ch.ready, out_valid_q && $stable(out_left_q) && $stable(out_right_q) && $stable(out_delay_q), "output word changed while stalled")
  `SFDL_ASSERT_NOW(in_blocked, out_valid_q && !out_ch.ready, !in_ch.ready, "input open while output stalled")

endmodule

### dv/testbench.sv
module testbench;
  import sfdl_pkg::*;

  localparam int          SW            = SAMPLE_BITS_DEF;
  localparam int          DW            = DELAY_W_DEF;
  localparam int          FB            = FRAC_BITS_DEF;
  localparam int unsigned DEPTH         = MAX_DELAY_DEF + 1;
  localparam longint      DELAY_TOP     = longint'(MAX_DELAY_DEF) << FB;
  localparam longint      SLEW          = longint'(1) << (FB - 2);
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 300;
  localparam int          PHASES        = 9;
  localparam int          WORDS_PER_PH  = 72;
  localparam int          DRAIN_LIMIT   = 5000;
  localparam int          CYCLE_LIMIT   = 600000;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic [DW-1:0]        delay;
  } interp_word_t;

  typedef enum logic [0:0] {ROW_WORD, ROW_TARGET} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic                 restart;
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 typed;
    interp_word_t         want;
    logic [DW-1:0]        target;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [DW-1:0] cfg_wdata_i;

  sfdl_in_if  in_ch ();
  sfdl_out_if out_ch ();

  slewed_fractional_delay_line dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Shadow of the delay line: store, write pointer, slewed delay, target
  logic signed [SW-1:0] line_left  [DEPTH];
  logic signed [SW-1:0] line_right [DEPTH];
  int unsigned          line_wp;
  longint               line_delay;
  logic [DW-1:0]        line_target;

  interp_word_t due_words[$];
  row_t         directed[$];

  int errors          = 0;
  int results_checked = 0;
  int words_sent      = 0;
  int restarts_sent   = 0;
  int targets_set     = 0;
  int holds_done      = 0;
  int cycle_count     = 0;
  bit no_idle         = 1'b0;
  bit hold_request    = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Blend two neighbors, floor on the fraction product
  function automatic longint lerp(input longint early, input longint late,
                                  input longint frac);
    longint p;
    p = (late - early) * frac;
    return early + (p >>> FB);
  endfunction

  // Advance the shadow line by one word; return 1 when a result is due
  function automatic bit interp_step(input logic rs, input logic signed [SW-1:0] l,
                                     input logic signed [SW-1:0] r,
                                     output interp_word_t w);
    longint      lim;
    longint      diff;
    longint      pos;
    longint      frac;
    int unsigned lo;
    int unsigned hi;
    w   = '0;
    lim = (longint'(line_target) > DELAY_TOP) ? DELAY_TOP : longint'(line_target);
    if (rs) begin
      for (int i = 0; i < DEPTH; i++) begin
        line_left[i]  = '0;
        line_right[i] = '0;
      end
      line_wp    = 0;
      line_delay = lim;
      return 1'b0;
    end
    // Slew the delay by at most a quarter frame
    diff = lim - line_delay;
    if (diff > SLEW) diff = SLEW;
    if (diff < -SLEW) diff = -SLEW;
    line_delay += diff;
    line_left[line_wp]  = l;
    line_right[line_wp] = r;
    // Read behind the write pointer, wrapped into the store
    pos = (longint'(line_wp) << FB) - line_delay;
    if (pos < 0) pos += longint'(DEPTH) << FB;
    lo = int'(pos >> FB);
    if (lo >= DEPTH) lo = 0;
    hi = lo + 1;
    if (hi >= DEPTH) hi = 0;
    frac    = pos & ((longint'(1) << FB) - 1);
    w.left  = SW'(lerp(line_left[lo], line_left[hi], frac));
    w.right = SW'(lerp(line_right[lo], line_right[hi], frac));
    w.delay = DW'(line_delay);
    line_wp = (line_wp + 1 >= DEPTH) ? 0 : line_wp + 1;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic row_t word_row(input logic rs, input logic signed [SW-1:0] l,
                                    input logic signed [SW-1:0] r);
    row_t row;
    row         = '0;
    row.kind    = ROW_WORD;
    row.restart = rs;
    row.left    = l;
    row.right   = r;
    return row;
  endfunction

  function automatic row_t typed_row(input logic signed [SW-1:0] l,
                                     input logic signed [SW-1:0] r,
                                     input logic signed [SW-1:0] wl,
                                     input logic signed [SW-1:0] wr,
                                     input logic [DW-1:0] wd);
    row_t row;
    row            = word_row(1'b0, l, r);
    row.typed      = 1'b1;
    row.want.left  = wl;
    row.want.right = wr;
    row.want.delay = wd;
    return row;
  endfunction

  function automatic row_t target_row(input logic [DW-1:0] v);
    row_t row;
    row        = '0;
    row.kind   = ROW_TARGET;
    row.target = v;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40)
      $display("mismatch at result %0d: %s got %0d, want %0d",
               results_checked, what, got, want);
  endtask

  // Offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(input logic rs, input logic signed [SW-1:0] l,
                           input logic signed [SW-1:0] r, input logic typed,
                           input interp_word_t want);
    int           gap;
    interp_word_t w;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.restart  <= rs;
    in_ch.in_left  <= l;
    in_ch.in_right <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    if (rs) restarts_sent++;
    else words_sent++;
    if (interp_step(rs, l, r, w)) begin
      if (typed) w = want;
      due_words.push_back(w);
    end
  endtask

  // Drop valid and wait for the line to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [DW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    line_target = v;
    targets_set++;
  endtask

  // Output side: random stalls, one long hold on request
  initial begin : sink_side
    int stall;
    int run;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_done++;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        run = $urandom_range(1, 12);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Compare each taken result word with the oldest one due
  always @(posedge clk_i) begin : result_check
    interp_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected result, left", longint'(out_ch.out_left), 0);
      end else begin
        want = due_words.pop_front();
        if (out_ch.out_left !== want.left)
          report_mismatch("left", longint'(out_ch.out_left), longint'(want.left));
        if (out_ch.out_right !== want.right)
          report_mismatch("right", longint'(out_ch.out_right), longint'(want.right));
        if (out_ch.delay_now !== want.delay)
          report_mismatch("delay", longint'(out_ch.delay_now), longint'(want.delay));
      end
      results_checked++;
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    row_t          row;
    logic [DW-1:0] tgt;
    int            waited;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.restart  = 1'b0;
    in_ch.in_left  = '0;
    in_ch.in_right = '0;
    line_target    = '0;
    void'(interp_step(1'b1, '0, '0, row.want));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero delay after reset: each word comes straight back
    directed.push_back(typed_row(S_MAX, S_MIN, S_MAX, S_MIN, '0));
    directed.push_back(typed_row(S_MIN, S_MAX, S_MIN, S_MAX, '0));
    directed.push_back(typed_row('0, -1, '0, -1, '0));
    directed.push_back(word_row(1'b1, 24'sh5a5a5a, -24'sh5a5a5a));
    directed.push_back(typed_row(24'sh123456, -24'sh123456, 24'sh123456, -24'sh123456, '0));
    // Target above the maximum, full-swing neighbors to blend
    directed.push_back(target_row('1));
    directed.push_back(word_row(1'b0, S_MAX, S_MIN));
    directed.push_back(word_row(1'b0, S_MIN, S_MAX));
    directed.push_back(word_row(1'b0, S_MAX, S_MIN));
    directed.push_back(word_row(1'b0, S_MIN, S_MAX));
    // Restart snaps to the saturated delay and reads the cleared store
    directed.push_back(word_row(1'b1, S_MAX, S_MAX));
    directed.push_back(typed_row(S_MAX, S_MIN, '0, '0, DW'(DELAY_TOP)));
    directed.push_back(typed_row(S_MIN, S_MAX, '0, '0, DW'(DELAY_TOP)));
    // Quarter-frame delay right after restart: read wraps to the top entry
    directed.push_back(target_row(DW'(SLEW)));
    directed.push_back(word_row(1'b1, '0, '0));
    directed.push_back(word_row(1'b0, S_MAX, S_MIN));
    directed.push_back(word_row(1'b0, S_MIN, S_MAX));
    // Slew back down to zero
    directed.push_back(target_row('0));
    directed.push_back(word_row(1'b0, -1, 24'sh000001));
    directed.push_back(word_row(1'b0, 24'sh400000, -24'sh400000));
    // Fractional target, odd fraction bits
    directed.push_back(target_row(DW'(18'h2a5)));
    directed.push_back(word_row(1'b0, 24'sh2aaaaa, -24'sh155555));
    directed.push_back(word_row(1'b0, 24'sh00ff00, S_MIN + 1));
    directed.push_back(word_row(1'b0, S_MAX - 1, 24'sh0f0f0f));
    directed.push_back(word_row(1'b0, -24'sh333333, 24'sh7f0001));

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_TARGET) begin
        settle();
        write_target(row.target);
      end else begin
        send_word(row.restart, row.left, row.right, row.typed, row.want);
      end
    end

    // Random phases, each under its own target
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       tgt = DW'(DELAY_TOP);
        1:       tgt = '1;
        2:       tgt = '0;
        3:       tgt = DW'($urandom_range(0, 16 << FB));
        6:       tgt = DW'(SLEW);
        default: tgt = ($urandom_range(0, 3) == 0) ? DW'($urandom)
                                                   : DW'($urandom_range(0, 24 << FB));
      endcase
      write_target(tgt);
      no_idle = (ph == 3 || ph == 6);
      if (ph == 4) hold_request = 1'b1;
      if ($urandom_range(0, 1) == 1)
        send_word(1'b1, pick_sample(), pick_sample(), 1'b0, '0);
      for (int k = 0; k < WORDS_PER_PH; k++)
        send_word($urandom_range(0, 29) == 0, pick_sample(), pick_sample(), 1'b0, '0);
    end

    // Drain and close out
    in_ch.valid <= 1'b0;
    waited = 0;
    while (due_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_words.size() != 0)
      report_mismatch("results never produced", due_words.size(), 0);

    $display("ran %0d sample words and %0d restarts under %0d target settings",
             words_sent, restarts_sent, targets_set);
    $display("checked %0d results with %0d long output holds, %0d mismatches",
             results_checked, holds_done, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
